// ----- rtl/oss_pkg.sv -----
// Shared types and constants for the odd-only segmented prime sieve.
// No dependencies; imported by every module of the block.
package oss_pkg;

  localparam int LIMIT_W    = 21;
  localparam int IDX_W      = 6;
  localparam int RCNT_W     = 7;
  localparam int CFG_W      = 7;
  localparam int CFG_AW     = 1;
  localparam int ELEM_W     = 19;
  localparam int MARK_AW    = 19;
  localparam int MARK_DEPTH = 1 << MARK_AW;
  localparam int BASE_AW    = 9;
  localparam int BASE_DEPTH = 1 << BASE_AW;
  localparam int ROOT_W     = 11;
  localparam int Q_W        = 11;
  localparam int J_W        = 12;
  localparam int SQ_W       = 22;
  localparam int KW         = 20;
  localparam int COUNT_W    = 20;
  localparam int DVD_W      = 25;
  localparam int DVS_W      = 11;
  localparam int DCNT_W     = 5;
  localparam int TDATA_W    = 24;

  localparam logic [LIMIT_W-1:0] MAX_LIMIT  = LIMIT_W'(1048576);
  localparam logic [RCNT_W-1:0]  MAX_SLICES = RCNT_W'(64);

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_RANK_INDEX = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_RANK_COUNT = 1'b1;

  // divider operand selection
  localparam logic [1:0] DIV_LO  = 2'd0;
  localparam logic [1:0] DIV_HI  = 2'd1;
  localparam logic [1:0] DIV_MOD = 2'd2;

  typedef struct packed {
    logic       init_step;
    logic       load;
    logic       setup;
    logic       prod;
    logic       sqrt_step;
    logic       div_go;
    logic [1:0] div_sel;
    logic       lo_take;
    logic       hi_take;
    logic       bclr_step;
    logic       bread;
    logic       bsetup;
    logic       bmark_step;
    logic       k_direct;
    logic       mod_take;
    logic       smark_step;
    logic       next_base;
    logic       count_init;
    logic       count_step;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic init_last;
    logic empty;
    logic sqrt_last;
    logic div_done;
    logic base_last;
    logic base_marked;
    logic bmark_end;
    logic need_mod;
    logic k_end;
    logic out_valid;
  } dp_sts_t;

endpackage

// ----- rtl/oss_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on oss_pkg for widths.
module oss_div import oss_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quot,
  output logic [DVS_W-1:0] rem
);

  logic [DVS_W-1:0]  dvs;
  logic [DCNT_W-1:0] cnt;
  logic              busy;
  logic [DVS_W:0]    sh;
  logic              fits;

  assign sh   = {rem, quot[DVD_W-1]};
  assign fits = sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(DVD_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      // subtract when the shifted remainder covers the divisor
      rem  <= fits ? DVS_W'(sh - {1'b0, dvs}) : sh[DVS_W-1:0];
      quot <= {quot[DVD_W-2:0], fits};
    end
  end

endmodule

// ----- rtl/oss_ctrl.sv -----
// Sequencer for the sieve: steps the datapath through each request.
// Depends on oss_pkg for the command and status structs.
module oss_ctrl import oss_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [19:0] {
    ST_INIT   = 20'h00001,
    ST_IDLE   = 20'h00002,
    ST_SETUP  = 20'h00004,
    ST_PROD   = 20'h00008,
    ST_SQRT   = 20'h00010,
    ST_LOGO   = 20'h00020,
    ST_LOW    = 20'h00040,
    ST_HIGO   = 20'h00080,
    ST_HIW    = 20'h00100,
    ST_BCLR   = 20'h00200,
    ST_BREAD  = 20'h00400,
    ST_BWAIT  = 20'h00800,
    ST_BMARK  = 20'h01000,
    ST_KSET   = 20'h02000,
    ST_MODW   = 20'h04000,
    ST_SMARK  = 20'h08000,
    ST_NEXT   = 20'h10000,
    ST_COUNT  = 20'h20000,
    ST_CDRAIN = 20'h40000,
    ST_DONE   = 20'h80000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_INIT;
    else     state <= state_next;
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.init_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_PROD;
      end
      ST_PROD: begin
        if (sts.empty) begin
          cmd.count_init = 1'b1;
          state_next     = ST_DONE;
        end else begin
          cmd.prod   = 1'b1;
          state_next = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_last) state_next = ST_LOGO;
      end
      ST_LOGO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_LO;
        state_next  = ST_LOW;
      end
      ST_LOW: begin
        if (sts.div_done) begin
          cmd.lo_take = 1'b1;
          state_next  = ST_HIGO;
        end
      end
      ST_HIGO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_HI;
        state_next  = ST_HIW;
      end
      ST_HIW: begin
        if (sts.div_done) begin
          cmd.hi_take = 1'b1;
          state_next  = ST_BCLR;
        end
      end
      ST_BCLR: begin
        cmd.bclr_step = 1'b1;
        if (sts.base_last) state_next = ST_BREAD;
      end
      ST_BREAD: begin
        cmd.bread  = 1'b1;
        state_next = ST_BWAIT;
      end
      ST_BWAIT: begin
        if (sts.base_marked) begin
          state_next = ST_NEXT;
        end else begin
          cmd.bsetup = 1'b1;
          state_next = ST_BMARK;
        end
      end
      ST_BMARK: begin
        if (sts.bmark_end) state_next = ST_KSET;
        else               cmd.bmark_step = 1'b1;
      end
      ST_KSET: begin
        if (sts.need_mod) begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = DIV_MOD;
          state_next  = ST_MODW;
        end else begin
          cmd.k_direct = 1'b1;
          state_next   = ST_SMARK;
        end
      end
      ST_MODW: begin
        if (sts.div_done) begin
          cmd.mod_take = 1'b1;
          state_next   = ST_SMARK;
        end
      end
      ST_SMARK: begin
        if (sts.k_end) state_next = ST_NEXT;
        else           cmd.smark_step = 1'b1;
      end
      ST_NEXT: begin
        if (sts.base_last) begin
          cmd.count_init = 1'b1;
          state_next     = ST_COUNT;
        end else begin
          cmd.next_base = 1'b1;
          state_next    = ST_BREAD;
        end
      end
      ST_COUNT: begin
        if (sts.k_end) state_next = ST_CDRAIN;
        else           cmd.count_step = 1'b1;
      end
      ST_CDRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_valid) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_INIT;
    endcase
  end

endmodule

// ----- rtl/oss_dp.sv -----
// Datapath for the sieve: request registers, root search, mark stores,
// counting and the result register. Depends on oss_pkg and oss_div.
module oss_dp import oss_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic [LIMIT_W-1:0] limit,
  input  logic [IDX_W-1:0]   rank_index,
  input  logic [RCNT_W-1:0]  rank_count,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [COUNT_W-1:0] odd_prime_count
);

  logic [LIMIT_W-1:0] lim;
  logic [RCNT_W-1:0]  p;
  logic [IDX_W-1:0]   id;
  logic [ELEM_W-1:0]  elems, lo, size;
  logic [DVD_W-1:0]   prod_lo, prod_hi;
  logic [ROOT_W-1:0]  root, sq_b, trial, root_m1;
  logic [SQ_W-1:0]    trial_sq, qq, kdiff;
  logic [BASE_AW-1:0] be, i;
  logic [Q_W-1:0]     q, d;
  logic [J_W-1:0]     j, off;
  logic [LIMIT_W-1:0] low, lim_m1;
  logic [KW-1:0]      k;
  logic [COUNT_W-1:0] count;
  logic [MARK_AW-1:0] init_addr;
  logic               rd_v, mark_rd, base_rd;

  logic [DVD_W-1:0]   div_dvd, quot;
  logic [DVS_W-1:0]   div_dvs, rem;
  logic               div_done;

  logic               mark_mem [MARK_DEPTH];
  logic               base_mem [BASE_DEPTH];
  logic               mwe, mdata, bwe, bdata;
  logic [MARK_AW-1:0] maddr;
  logic [BASE_AW-1:0] baddr;

  assign trial    = root | sq_b;
  assign trial_sq = SQ_W'(trial) * SQ_W'(trial);
  assign root_m1  = root - 1'b1;
  assign be       = root_m1[BASE_AW:1];
  assign lim_m1   = lim - 1'b1;
  assign kdiff    = qq - SQ_W'(low);
  assign d        = (rem == '0) ? '0 : q - rem;
  assign off      = d[0] ? J_W'(d) + J_W'(q) : J_W'(d);

  always_comb begin
    case (cmd.div_sel)
      DIV_LO:  begin div_dvd = prod_lo;        div_dvs = DVS_W'(p); end
      DIV_HI:  begin div_dvd = prod_hi;        div_dvs = DVS_W'(p); end
      DIV_MOD: begin div_dvd = DVD_W'(low);    div_dvs = q;         end
      default: begin div_dvd = prod_lo;        div_dvs = DVS_W'(p); end
    endcase
  end

  oss_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_go),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  always_comb begin
    sts             = '0;
    sts.init_last   = (init_addr == '1);
    sts.empty       = (p == '0) || ({1'b0, id} >= p) || (elems == '0);
    sts.sqrt_last   = sq_b[0];
    sts.div_done    = div_done;
    sts.base_last   = (i == be);
    sts.base_marked = base_rd;
    sts.bmark_end   = j > J_W'(be);
    sts.need_mod    = qq < SQ_W'(low);
    sts.k_end       = k >= KW'(size);
    sts.out_valid   = out_valid;
  end

  // request state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lim  <= (limit > MAX_LIMIT) ? MAX_LIMIT : limit;
      p    <= (rank_count > MAX_SLICES) ? MAX_SLICES : rank_count;
      id   <= rank_index;
      root <= '0;
      sq_b <= ROOT_W'(1) << (ROOT_W - 1);
    end
    if (cmd.setup) elems <= (lim >= LIMIT_W'(3)) ? lim_m1[ELEM_W:1] : '0;
    if (cmd.prod) begin
      prod_lo <= DVD_W'(id) * DVD_W'(elems);
      prod_hi <= (DVD_W'(id) + DVD_W'(1)) * DVD_W'(elems);
    end
    if (cmd.sqrt_step) begin
      if (trial_sq <= SQ_W'(lim)) root <= trial;
      sq_b <= sq_b >> 1;
    end
    if (cmd.lo_take) begin
      lo  <= quot[ELEM_W-1:0];
      low <= LIMIT_W'({quot[ELEM_W-1:0], 1'b1}) + LIMIT_W'(2);
    end
    if (cmd.hi_take) size <= quot[ELEM_W-1:0] - lo;
    if (cmd.hi_take) begin
      i <= '0;
    end else if (cmd.bclr_step) begin
      i <= sts.base_last ? '0 : i + 1'b1;
    end else if (cmd.next_base) begin
      i <= i + 1'b1;
    end
    if (cmd.bread) q <= Q_W'({i, 1'b1}) + Q_W'(2);
    if (cmd.bsetup) begin
      j  <= J_W'(i) + J_W'(q);
      qq <= SQ_W'(q) * SQ_W'(q);
    end else if (cmd.bmark_step) begin
      j <= j + J_W'(q);
    end
    if (cmd.k_direct)                          k <= kdiff[KW:1];
    else if (cmd.mod_take)                     k <= KW'(off[J_W-1:1]);
    else if (cmd.smark_step || cmd.count_step) k <= k + (cmd.smark_step ? KW'(q) : KW'(1));
    else if (cmd.count_init)                   k <= '0;
  end

  // counting pass: read, clear behind, tally in the cycle after the read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v      <= 1'b0;
      init_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      rd_v <= cmd.count_step;
      if (cmd.init_step) init_addr <= init_addr + 1'b1;
      if (cmd.out_load)  out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.count_init)         count <= '0;
    else if (rd_v && !mark_rd)  count <= count + 1'b1;
    if (cmd.out_load) odd_prime_count <= count;
  end

  assign mwe   = cmd.init_step | cmd.smark_step | cmd.count_step;
  assign maddr = cmd.init_step ? init_addr : k[MARK_AW-1:0];
  assign mdata = cmd.smark_step;
  assign bwe   = cmd.bclr_step | cmd.bmark_step;
  assign baddr = cmd.bmark_step ? j[BASE_AW-1:0] : i;
  assign bdata = cmd.bmark_step;

  always_ff @(posedge clk) begin
    if (mwe) mark_mem[maddr] <= mdata;
    if (cmd.count_step) mark_rd <= mark_mem[k[MARK_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (bwe) base_mem[baddr] <= bdata;
    if (cmd.bread) base_rd <= base_mem[i];
  end

endmodule

// ----- rtl/odd_only_segmented_prime_sieve.sv -----
// Odd-only segmented prime sieve: counts the odd primes in one slice of 3..n.
// Per request: setup (11-step root search, two divisions for the slice bounds),
// clearing and walking the base store, for each base prime a remainder division
// where its first multiple needs one and one mark written per multiple, a counting
// pass over the slice, then loading the result; an empty slice goes straight to the
// result. One request at a time. Reset (rst, synchronous) clears all 524288 marks.
module odd_only_segmented_prime_sieve import oss_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,   // [20:0] limit
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [19:0] odd_prime_count
  input  logic               cfg_we,
  input  logic [CFG_AW-1:0]  cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  logic [IDX_W-1:0]   rank_index;
  logic [RCNT_W-1:0]  rank_count;
  logic [COUNT_W-1:0] odd_prime_count;
  dp_cmd_t            cmd;
  dp_sts_t            sts;

  // configuration registers; the user must write them only while the block is idle, the block leaves this unchecked
  always_ff @(posedge clk) begin
    if (rst) begin
      rank_index <= '0;
      rank_count <= RCNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RANK_INDEX: rank_index <= cfg_wdata[IDX_W-1:0];
        CFG_RANK_COUNT: rank_count <= cfg_wdata[RCNT_W-1:0];
        default:        ;
      endcase
    end
  end

  // sequencer: one request in flight, result held until taken
  oss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: divider, root search, both mark stores and the count
  oss_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .limit           (s_tdata[LIMIT_W-1:0]),
    .rank_index      (rank_index),
    .rank_count      (rank_count),
    .out_ready       (m_tready),
    .out_valid       (m_tvalid),
    .odd_prime_count (odd_prime_count)
  );

  // pad the count to whole bytes
  assign m_tdata = TDATA_W'(odd_prime_count);

endmodule
